>>> rtl/hsl_to_rgb_color_convert_macros.svh
// Assertion helpers for the checker file hsl_checker.sv.
`ifndef HSL_TO_RGB_COLOR_CONVERT_MACROS_SVH
`define HSL_TO_RGB_COLOR_CONVERT_MACROS_SVH

// Check that ante implies cons on every clock outside reset.
`define HSL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that expr never holds outside reset.
`define HSL_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

>>> rtl/hsl_pkg.sv
`default_nettype none
package hsl_pkg;

  localparam int CHANNEL_BITS      = 8;
  localparam int HUE_FRACTION_BITS = 6;

  localparam int HUE_BITS   = 9 + HUE_FRACTION_BITS;
  localparam int CH_MAX     = (1 << CHANNEL_BITS) - 1;
  // V and M are scaled by CH_MAX^2 and fit twice the channel width
  localparam int VAL_BITS   = 2 * CHANNEL_BITS;
  localparam int SEXT_W     = 60 << HUE_FRACTION_BITS;
  localparam int FRAC_BITS  = 6 + HUE_FRACTION_BITS;
  localparam int NUM_BITS   = VAL_BITS + FRAC_BITS;

  // Number of sextant boundaries a full-range hue can cross
  localparam int HUE_STEPS  = ((1 << HUE_BITS) - 1) / SEXT_W;
  localparam int QUOT_BITS  = $clog2(HUE_STEPS + 1);

  // Rounding divide by CH_MAX * SEXT_W via reciprocal
  localparam longint unsigned DIV_D       = longint'(CH_MAX) * longint'(SEXT_W);
  localparam longint unsigned HALF_D      = DIV_D / 2;
  localparam int              RECIP_SHIFT = NUM_BITS + 2;
  localparam longint unsigned RECIP       = (64'd1 << RECIP_SHIFT) / DIV_D;
  localparam int              RECIP_BITS  = $clog2(RECIP + 1);

  localparam int LATENCY = 5;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [HUE_BITS-1:0]     hue_t;
  typedef logic [VAL_BITS-1:0]     val_t;
  typedef logic [FRAC_BITS-1:0]    frac_t;
  typedef logic [NUM_BITS-1:0]     num_t;
  typedef logic [2:0]              sext_t;

  typedef struct packed {
    hue_t  hue;
    chan_t saturation;
    chan_t lightness;
    chan_t alpha_in;
  } pixel_in_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha_out;
  } pixel_out_t;

endpackage
`default_nettype wire

>>> rtl/hsl_round_div.sv
`default_nettype none
// Two-stage rounding divide: quotient of a pre-biased numerator by CH_MAX*SEXT_W.
module hsl_round_div (
  input  wire logic          clk,
  input  wire hsl_pkg::num_t num,
  output hsl_pkg::chan_t     quot
);

  localparam int NB = hsl_pkg::NUM_BITS;
  localparam int PB = hsl_pkg::NUM_BITS + hsl_pkg::RECIP_BITS;

  logic [PB-1:0]  prod;
  hsl_pkg::chan_t q_est;
  hsl_pkg::num_t  num_hold;
  logic [NB-1:0]  q_times_d;
  logic [NB-1:0]  rem;
  hsl_pkg::chan_t quot_next;

  // Estimate is exact or one low
  assign prod = PB'(num) * PB'(hsl_pkg::RECIP);

  always_ff @(posedge clk) begin
    q_est    <= prod[hsl_pkg::RECIP_SHIFT +: hsl_pkg::CHANNEL_BITS];
    num_hold <= num;
  end

  always_comb begin
    q_times_d = NB'(q_est) * NB'(hsl_pkg::DIV_D);
    rem       = num_hold - q_times_d;
    quot_next = (rem >= NB'(hsl_pkg::DIV_D)) ? q_est + 1'b1 : q_est;
  end

  always_ff @(posedge clk) begin
    quot <= quot_next;
  end

endmodule
`default_nettype wire

>>> rtl/hsl_to_rgb_color_convert.sv
// Throughput: one word per clock; busy stays low, so start may be held every cycle.
// Five register stages set the latency: V and hue split, M and span, channel pick,
// divide estimate, divide correction; no stage ever stalls.
// done is a one-cycle strobe; the receiver cannot stall it.
// rst (synchronous) clears the valid pipe; words in flight are dropped.
`default_nettype none
module hsl_to_rgb_color_convert (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire hsl_pkg::pixel_in_t pixel,
  output logic                    done,
  output hsl_pkg::pixel_out_t     result
);

  localparam int CB = hsl_pkg::CHANNEL_BITS;
  localparam int VB = hsl_pkg::VAL_BITS;
  localparam int NB = hsl_pkg::NUM_BITS;
  localparam int QB = hsl_pkg::QUOT_BITS;

  // valid pipe, stage 1 .. 5
  logic [hsl_pkg::LATENCY-1:0] valid;

  // stage 1: V, sextant, fraction
  hsl_pkg::val_t  v1;
  hsl_pkg::chan_t l1;
  hsl_pkg::sext_t k1;
  hsl_pkg::frac_t f1;
  hsl_pkg::chan_t a1;
  hsl_pkg::val_t  v1_next;
  hsl_pkg::sext_t k1_next;
  hsl_pkg::frac_t f1_next;

  // stage 2: V, M, ramp span
  hsl_pkg::val_t  v2;
  hsl_pkg::val_t  m2;
  hsl_pkg::num_t  span2;
  hsl_pkg::sext_t k2;
  hsl_pkg::chan_t a2;
  hsl_pkg::val_t  m2_next;
  hsl_pkg::num_t  span2_next;

  // stage 3: biased channel numerators
  hsl_pkg::num_t  xr;
  hsl_pkg::num_t  xg;
  hsl_pkg::num_t  xb;
  hsl_pkg::chan_t a3;
  hsl_pkg::num_t  xr_next;
  hsl_pkg::num_t  xg_next;
  hsl_pkg::num_t  xb_next;

  // stages 4 and 5 live in the dividers; alpha rides alongside
  hsl_pkg::chan_t a4;
  hsl_pkg::chan_t a5;
  hsl_pkg::chan_t red_q;
  hsl_pkg::chan_t green_q;
  hsl_pkg::chan_t blue_q;

  logic          accept;
  logic [VB-1:0] ls;
  logic [VB-1:0] lc;
  logic [VB-1:0] sc;
  logic [QB-1:0] hq;
  logic [QB-1:0] sext_full;
  logic [VB:0]   two_lc;
  logic [VB-1:0] diff;
  logic [NB-1:0] vw;
  logic [NB-1:0] mw;
  logic [NB-1:0] up;
  logic [NB-1:0] dn;
  logic [NB-1:0] rn;
  logic [NB-1:0] gn;
  logic [NB-1:0] bn;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[hsl_pkg::LATENCY-2:0], accept};
    end
  end

  // Stage 1: V = l(C+s) for low lightness, else lC + sC - ls; split hue
  always_comb begin
    ls = VB'(pixel.lightness) * VB'(pixel.saturation);
    lc = (VB'(pixel.lightness) << CB) - VB'(pixel.lightness);
    sc = (VB'(pixel.saturation) << CB) - VB'(pixel.saturation);
    if ((VB'(pixel.lightness) << 1) <= VB'(hsl_pkg::CH_MAX)) begin
      v1_next = lc + ls;
    end else begin
      v1_next = lc + sc - ls;
    end

    hq = '0;
    for (int i = 1; i <= hsl_pkg::HUE_STEPS; i++) begin
      if (int'(pixel.hue) >= i * hsl_pkg::SEXT_W) begin
        hq = hq + 1'b1;
      end
    end
    f1_next   = hsl_pkg::FRAC_BITS'(int'(pixel.hue) - int'(hq) * hsl_pkg::SEXT_W);
    // wrap past 360 degrees
    sext_full = (hq >= QB'(6)) ? hq - QB'(6) : hq;
    k1_next   = 3'(sext_full);
  end

  always_ff @(posedge clk) begin
    v1 <= v1_next;
    l1 <= pixel.lightness;
    k1 <= k1_next;
    f1 <= f1_next;
    a1 <= pixel.alpha_in;
  end

  // Stage 2: M = 2lC - V, span = (V - M) * f
  always_comb begin
    two_lc     = ((VB + 1)'(l1) << (CB + 1)) - ((VB + 1)'(l1) << 1);
    m2_next    = VB'(two_lc - (VB + 1)'(v1));
    diff       = v1 - m2_next;
    span2_next = NB'(diff) * NB'(f1);
  end

  always_ff @(posedge clk) begin
    v2    <= v1;
    m2    <= m2_next;
    span2 <= span2_next;
    k2    <= k1;
    a2    <= a1;
  end

  // Stage 3: scale to sextant width, pick ramps, add half divisor for rounding.
  // Zero V forces l = 0, so every channel already rounds to zero.
  always_comb begin
    vw = NB'(v2) * NB'(hsl_pkg::SEXT_W);
    mw = NB'(m2) * NB'(hsl_pkg::SEXT_W);
    up = mw + span2;
    dn = vw - span2;
    unique case (k2)
      3'd0: begin
        rn = vw; gn = up; bn = mw;
      end
      3'd1: begin
        rn = dn; gn = vw; bn = mw;
      end
      3'd2: begin
        rn = mw; gn = vw; bn = up;
      end
      3'd3: begin
        rn = mw; gn = dn; bn = vw;
      end
      3'd4: begin
        rn = up; gn = mw; bn = vw;
      end
      default: begin
        rn = vw; gn = mw; bn = dn;
      end
    endcase
    xr_next = rn + NB'(hsl_pkg::HALF_D);
    xg_next = gn + NB'(hsl_pkg::HALF_D);
    xb_next = bn + NB'(hsl_pkg::HALF_D);
  end

  always_ff @(posedge clk) begin
    xr <= xr_next;
    xg <= xg_next;
    xb <= xb_next;
    a3 <= a2;
  end

  // Stages 4 and 5
  hsl_round_div u_div_red (
    .clk  (clk),
    .num  (xr),
    .quot (red_q)
  );

  hsl_round_div u_div_green (
    .clk  (clk),
    .num  (xg),
    .quot (green_q)
  );

  hsl_round_div u_div_blue (
    .clk  (clk),
    .num  (xb),
    .quot (blue_q)
  );

  always_ff @(posedge clk) begin
    a4 <= a3;
    a5 <= a4;
  end

  assign done             = valid[hsl_pkg::LATENCY-1];
  assign result.red       = red_q;
  assign result.green     = green_q;
  assign result.blue      = blue_q;
  assign result.alpha_out = a5;

endmodule
`default_nettype wire

>>> rtl/hsl_checker.sv
`default_nettype none
`include "hsl_to_rgb_color_convert_macros.svh"
module hsl_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire hsl_pkg::pixel_in_t  pixel,
  input wire logic                done,
  input wire hsl_pkg::pixel_out_t result
);

  localparam int LAT = hsl_pkg::LATENCY;

  logic           take;
  logic           gray_in;
  logic           gray_out;
  hsl_pkg::chan_t a_in;

  assign take     = start && !busy;
  assign gray_in  = (pixel.saturation == '0);
  assign gray_out = (result.red == result.green) && (result.green == result.blue);
  assign a_in     = pixel.alpha_in;

  // every accepted word comes out after the fixed latency
  `HSL_ASSERT_IMPL(a_done_follows, take, ##LAT done, "word lost")
  // and nothing else comes out
  `HSL_ASSERT_IMPL(a_done_origin, done, $past(take, LAT), "extra word")
  `HSL_ASSERT_IMPL(a_alpha_pass, done, result.alpha_out == $past(a_in, LAT), "alpha changed")
  // zero saturation gives gray
  `HSL_ASSERT_IMPL(a_gray, done && $past(gray_in, LAT), gray_out, "not gray")

endmodule

bind hsl_to_rgb_color_convert hsl_checker u_checker (.*);
`default_nettype wire
